// ===== hw/rtl/text_console_writer_core_assert.svh =====
// Assertion macros for the text console writer core.
// Used by text_console_writer_core.sv; no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TCW_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/tcw_pkg.sv =====
// Types and constants shared by the text console writer core.
// No dependencies.
`default_nettype none

package tcw_pkg;

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } command_type;

   localparam logic [7:0] CH_BELL      = 8'd7;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_LF        = 8'd10;
   localparam logic [7:0] CH_CR        = 8'd13;
   localparam logic [7:0] SPACE_CODE   = 8'h20;
   localparam logic [7:0] RESET_ATTR   = 8'd7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_TAB,
      ST_BLANK
   } state_type;

   typedef struct packed {
      logic [7:0] attr;
      logic [7:0] chr;
   } cell_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } req_type;

   typedef struct packed {
      logic [6:0] cursor_col;
      logic [4:0] cursor_row;
      logic       bell;
      logic       scrolled;
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/text_console_writer_core.sv =====
// Text console writer core: screen store in one synchronous RAM, rows addressed
// through a rotating top-row base. Depends on tcw_pkg and the assertion header.
// Put, CR, LF, bell, backspace and unused codes answer in the cycle after the request;
// a read answers through the RAM output register and ST_READ; a tab writes spaces up
// to the next tab stop. A scroll first blanks the recycled row and a clear writes
// every cell before answering, one RAM write per cycle. Busy is low again while a
// result is strobed: puts run one per cycle unless a tab or scroll holds busy, and
// a read is taken only once the last has answered. Results cannot be stalled. The
// synchronous reset fills all cells with busy high; csr writes are still taken then.
`default_nettype none
`include "text_console_writer_core_assert.svh"

module text_console_writer_core
   import tcw_pkg::*;
#(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STEP = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  wire logic    csr_we,
   input  wire logic [7:0] csr_wdata
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);

   state_type         state_ff, state_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [RW-1:0]     base_ff, base_in;
   logic [7:0]        attr_ff;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic [AW-1:0]     sweep_end_ff, sweep_end_in;
   logic              tab_pend_ff, tab_pend_in;
   logic              quiet_ff, quiet_in;
   logic              scrolled_ff, scrolled_in;
   logic              rd_ok_ff, rd_ok_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   cell_type          mem [CELLS];
   cell_type          mem_rdata_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_addr;
   cell_type          mem_wdata;

   logic [COLUMNS-1:0] tab_stop;

   for (genvar g = 0; g < COLUMNS; g++) begin : g_tab_stop
      assign tab_stop[g] = (g >= 1) && (((g - 1) % TAB_STEP) == 0);
   end

   function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                               input logic [RW-1:0] b);
      logic [RW:0] s;
      s = {1'b0, r} + {1'b0, b};
      if (s >= (RW+1)'(ROWS)) begin
         s = s - (RW+1)'(ROWS);
      end
      return s[RW-1:0];
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] pr,
                                                input logic [CW-1:0] c);
      return AW'(pr) * AW'(COLUMNS) + AW'(c);
   endfunction

   logic              accept;
   logic [CW-1:0]     bs_col;
   logic              at_last_col;
   logic              at_last_row;
   logic [CW-1:0]     plain_col;
   logic              plain_scroll;
   logic [RW-1:0]     base_next;
   logic [AW-1:0]     row_start;
   logic [AW-1:0]     plain_addr;
   logic [AW-1:0]     read_addr;
   logic              read_ok;

   assign accept       = start && (state_ff == ST_IDLE);
   assign bs_col       = col_ff - CW'(1);
   assign at_last_col  = (col_ff == CW'(COLUMNS - 1));
   assign at_last_row  = (row_ff == RW'(ROWS - 1));
   assign plain_col    = at_last_col ? '0 : col_ff + CW'(1);
   assign plain_scroll = at_last_col && at_last_row;
   assign base_next    = (base_ff == RW'(ROWS - 1)) ? '0 : base_ff + RW'(1);
   assign row_start    = cell_addr(base_ff, '0);
   assign plain_addr   = cell_addr(phys_row(row_ff, base_ff), col_ff);
   assign read_ok      = (int'(req_data.read_row) < ROWS) &&
                         (int'(req_data.read_col) < COLUMNS);
   assign read_addr    = read_ok ? cell_addr(phys_row(RW'(req_data.read_row), base_ff),
                                             CW'(req_data.read_col)) : '0;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_data.command)
                  CMD_PUT: begin
                     if (req_data.char_code == CH_TAB) begin
                        state_in = ST_TAB;
                     end else if (req_data.char_code == CH_LF) begin
                        state_in = at_last_row ? ST_BLANK : ST_IDLE;
                     end else if (req_data.char_code inside {CH_BELL, CH_BACKSPACE,
                                                             CH_CR}) begin
                        state_in = ST_IDLE;
                     end else begin
                        state_in = plain_scroll ? ST_BLANK : ST_IDLE;
                     end
                  end
                  CMD_READ:  state_in = ST_READ;
                  CMD_CLEAR: state_in = ST_BLANK;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_TAB: begin
            if (plain_scroll) begin
               state_in = ST_BLANK;
            end else if (tab_stop[plain_col]) begin
               state_in = ST_IDLE;
            end
         end
         ST_BLANK: begin
            if (sweep_ff == sweep_end_ff) begin
               state_in = tab_pend_ff ? ST_TAB : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      logic rsp_bell;
      logic rsp_cell;
      col_in       = col_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      sweep_in     = sweep_ff;
      sweep_end_in = sweep_end_ff;
      tab_pend_in  = tab_pend_ff;
      quiet_in     = quiet_ff;
      scrolled_in  = scrolled_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = 1'b0;
      rsp_bell     = 1'b0;
      rsp_cell     = 1'b0;
      mem_we       = 1'b0;
      mem_addr     = plain_addr;
      mem_wdata    = '{attr: attr_ff, chr: SPACE_CODE};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               scrolled_in = 1'b0;
               tab_pend_in = 1'b0;
               quiet_in    = 1'b0;
               case (req_data.command)
                  CMD_PUT: begin
                     if (req_data.char_code == CH_BELL) begin
                        rsp_bell     = 1'b1;
                        rsp_valid_in = 1'b1;
                     end else if (req_data.char_code == CH_BACKSPACE) begin
                        if (col_ff != '0) begin
                           col_in   = bs_col;
                           mem_we   = 1'b1;
                           mem_addr = cell_addr(phys_row(row_ff, base_ff), bs_col);
                        end
                        rsp_valid_in = 1'b1;
                     end else if (req_data.char_code == CH_TAB) begin
                        rsp_valid_in = 1'b0;
                     end else if (req_data.char_code == CH_CR) begin
                        col_in       = '0;
                        rsp_valid_in = 1'b1;
                     end else if (req_data.char_code == CH_LF) begin
                        col_in = '0;
                        if (at_last_row) begin
                           base_in      = base_next;
                           sweep_in     = row_start;
                           sweep_end_in = row_start + AW'(COLUMNS - 1);
                           scrolled_in  = 1'b1;
                        end else begin
                           row_in       = row_ff + RW'(1);
                           rsp_valid_in = 1'b1;
                        end
                     end else begin
                        mem_we        = 1'b1;
                        mem_wdata.chr = req_data.char_code;
                        col_in        = plain_col;
                        if (plain_scroll) begin
                           base_in      = base_next;
                           sweep_in     = row_start;
                           sweep_end_in = row_start + AW'(COLUMNS - 1);
                           scrolled_in  = 1'b1;
                        end else begin
                           if (at_last_col) begin
                              row_in = row_ff + RW'(1);
                           end
                           rsp_valid_in = 1'b1;
                        end
                     end
                  end
                  CMD_READ: begin
                     mem_addr = read_addr;
                     rd_ok_in = read_ok;
                  end
                  CMD_CLEAR: begin
                     col_in       = '0;
                     row_in       = '0;
                     base_in      = '0;
                     sweep_in     = '0;
                     sweep_end_in = AW'(CELLS - 1);
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            rsp_cell     = rd_ok_ff;
            rsp_valid_in = 1'b1;
         end
         ST_TAB: begin
            mem_we = 1'b1;
            col_in = plain_col;
            if (plain_scroll) begin
               base_in      = base_next;
               sweep_in     = row_start;
               sweep_end_in = row_start + AW'(COLUMNS - 1);
               scrolled_in  = 1'b1;
               tab_pend_in  = 1'b1;
            end else begin
               if (at_last_col) begin
                  row_in = row_ff + RW'(1);
               end
               rsp_valid_in = tab_stop[plain_col];
            end
         end
         ST_BLANK: begin
            mem_we         = 1'b1;
            mem_addr       = sweep_ff;
            mem_wdata.attr = quiet_ff ? RESET_ATTR : attr_ff;
            sweep_in       = sweep_ff + AW'(1);
            if (sweep_ff == sweep_end_ff) begin
               rsp_valid_in = !tab_pend_ff && !quiet_ff;
               tab_pend_in  = 1'b0;
               quiet_in     = 1'b0;
            end
         end
         default: rsp_valid_in = 1'b0;
      endcase
      rsp_in.cursor_col = 7'(col_in);
      rsp_in.cursor_row = 5'(row_in);
      rsp_in.bell       = rsp_bell;
      rsp_in.scrolled   = scrolled_in;
      rsp_in.cell_char  = rsp_cell ? mem_rdata_ff.chr  : 8'd0;
      rsp_in.cell_attr  = rsp_cell ? mem_rdata_ff.attr : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_BLANK;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         attr_ff      <= RESET_ATTR;
         sweep_ff     <= '0;
         sweep_end_ff <= AW'(CELLS - 1);
         tab_pend_ff  <= 1'b0;
         quiet_ff     <= 1'b1;
         scrolled_ff  <= 1'b0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         base_ff      <= base_in;
         sweep_ff     <= sweep_in;
         sweep_end_ff <= sweep_end_in;
         tab_pend_ff  <= tab_pend_in;
         quiet_ff     <= quiet_in;
         scrolled_ff  <= scrolled_in;
         rd_ok_ff     <= rd_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            attr_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TCW_ASSERT_SAME(a_rsp_when_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE, "result strobed while busy")
   `TCW_ASSERT_NEXT(a_accept_progress, clock, reset, accept, busy || rsp_valid_ff, "request accepted without progress")
   `TCW_ASSERT_SAME(a_cursor_range, clock, reset, 1'b1, (int'(col_ff) < COLUMNS) && (int'(row_ff) < ROWS) && (int'(base_ff) < ROWS), "cursor or base out of range")

endmodule

`default_nettype wire

// ===== verif/text_console_writer_core_tb.sv =====
// Self-checking testbench for text_console_writer_core: directed table, then random
// command streams; each response is compared with a console screen predictor or,
// for some table rows, a fixed expected response. Depends on tcw_pkg and the core RTL.
`timescale 1ns / 1ps

module text_console_writer_core_tb;
   import tcw_pkg::*;

   localparam int SCREEN_COLS  = 80;
   localparam int SCREEN_ROWS  = 25;
   localparam int TAB_WIDTH    = 4;
   localparam int CELL_TOTAL   = SCREEN_COLS * SCREEN_ROWS;
   localparam int STALL_LIMIT  = 20000;
   localparam int PHASE_COUNT  = 6;
   localparam int PHASE_ITEMS  = 275;
   localparam int SEGMENT_LEN  = 40;
   localparam int DIR_ROWS     = 21;

   typedef struct {
      req_type req;
      bit      fixed_exp;
      rsp_type rsp;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we;
   logic [7:0] csr_wdata;

   cell_type   screen_img [0:CELL_TOTAL-1];
   int         cur_col;
   int         cur_row;
   logic [7:0] fill_attr;
   bit         scroll_seen;

   rsp_type     pending_rsp [$];
   int          mismatch_count;
   int          stall_cycles;
   dir_row_type dir_tab [DIR_ROWS];

   text_console_writer_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic req_type mk_req(logic [1:0] cmd, logic [7:0] ch, logic [4:0] row,
                                      logic [6:0] col);
      req_type r;
      r.command   = cmd;
      r.char_code = ch;
      r.read_row  = row;
      r.read_col  = col;
      return r;
   endfunction

   function automatic rsp_type mk_rsp(logic [6:0] col, logic [4:0] row, logic bl,
                                      logic scr, logic [7:0] ch, logic [7:0] at);
      rsp_type r;
      r.cursor_col = col;
      r.cursor_row = row;
      r.bell       = bl;
      r.scrolled   = scr;
      r.cell_char  = ch;
      r.cell_attr  = at;
      return r;
   endfunction

   function automatic cell_type blank_cell();
      cell_type c;
      c.attr = fill_attr;
      c.chr  = SPACE_CODE;
      return c;
   endfunction

   function automatic void fill_screen_img();
      for (int i = 0; i < CELL_TOTAL; i++) screen_img[i] = blank_cell();
   endfunction

   function automatic void scroll_screen_img();
      for (int i = 0; i < CELL_TOTAL - SCREEN_COLS; i++)
         screen_img[i] = screen_img[i + SCREEN_COLS];
      for (int i = CELL_TOTAL - SCREEN_COLS; i < CELL_TOTAL; i++)
         screen_img[i] = blank_cell();
      scroll_seen = 1'b1;
   endfunction

   function automatic void line_feed();
      cur_col = 0;
      if (cur_row == SCREEN_ROWS - 1) scroll_screen_img();
      else cur_row++;
   endfunction

   function automatic void write_char(logic [7:0] ch);
      screen_img[cur_row * SCREEN_COLS + cur_col].chr  = ch;
      screen_img[cur_row * SCREEN_COLS + cur_col].attr = fill_attr;
      cur_col++;
      if (cur_col >= SCREEN_COLS) line_feed();
   endfunction

   function automatic rsp_type console_apply(req_type r);
      rsp_type o;
      int      guard;
      o = '0;
      scroll_seen = 1'b0;
      case (r.command)
         CMD_PUT: begin
            if (r.char_code == CH_BELL) o.bell = 1'b1;
            case (r.char_code)
               CH_BELL: ;
               CH_BACKSPACE: begin
                  if (cur_col > 0) begin
                     cur_col--;
                     screen_img[cur_row * SCREEN_COLS + cur_col] = blank_cell();
                  end
               end
               CH_TAB: begin
                  guard = 0;
                  do begin
                     write_char(SPACE_CODE);
                     guard++;
                  end while (!(cur_col >= 1 && ((cur_col - 1) % TAB_WIDTH) == 0)
                             && guard <= 2 * SCREEN_COLS);
               end
               CH_LF: line_feed();
               CH_CR: cur_col = 0;
               default: write_char(r.char_code);
            endcase
         end
         CMD_READ: begin
            if (r.read_row < SCREEN_ROWS && r.read_col < SCREEN_COLS) begin
               o.cell_char = screen_img[r.read_row * SCREEN_COLS + r.read_col].chr;
               o.cell_attr = screen_img[r.read_row * SCREEN_COLS + r.read_col].attr;
            end
         end
         CMD_CLEAR: begin
            fill_screen_img();
            cur_col = 0;
            cur_row = 0;
         end
         default: ;
      endcase
      o.cursor_col = 7'(cur_col);
      o.cursor_row = 5'(cur_row);
      o.scrolled   = scroll_seen;
      return o;
   endfunction

   function automatic req_type random_req(int mode);
      req_type r;
      int      p;
      int      k;
      int      ctl_pct;
      r.command   = CMD_PUT;
      r.char_code = 8'($urandom_range(0, 255));
      r.read_row  = 5'($urandom);
      r.read_col  = 7'($urandom);
      p = $urandom_range(0, 999);
      if (p < 8) begin
         r.command = CMD_CLEAR;
      end else if (p < 25) begin
         r.command = CMD_NONE;
      end else if (p < 190) begin
         r.command = CMD_READ;
         k = $urandom_range(0, 9);
         if (k < 5) begin
            r.read_row = 5'(cur_row);
            r.read_col = 7'($urandom_range(0, SCREEN_COLS - 1));
         end else if (k < 8) begin
            r.read_row = 5'($urandom_range(0, SCREEN_ROWS - 1));
            r.read_col = 7'($urandom_range(0, SCREEN_COLS - 1));
         end
      end else begin
         ctl_pct = (mode == 0) ? 25 : ((mode == 1) ? 3 : 60);
         k = $urandom_range(0, 99);
         if (k < ctl_pct) begin
            case ($urandom_range(0, 5))
               0: r.char_code = CH_BELL;
               1: r.char_code = CH_BACKSPACE;
               2: r.char_code = CH_TAB;
               3: r.char_code = CH_CR;
               default: r.char_code = CH_LF;
            endcase
         end else if (mode == 1 && k < ctl_pct + 10) begin
            r.char_code = CH_TAB;
         end
      end
      return r;
   endfunction

   task automatic send_request(req_type r, bit fixed_exp, rsp_type exp_rsp, bit gapless);
      int unsigned gap;
      rsp_type     pred;
      gap = gapless ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      pred = console_apply(r);
      pending_rsp.push_back(fixed_exp ? exp_rsp : pred);
   endtask

   task automatic drain_all();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic write_fill_attr(logic [7:0] v);
      repeat (4) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      fill_attr = v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic check_field(string name, int e, int a);
      if (e != a) begin
         $error("%s: expected %0d, got %0d", name, e, a);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      rsp_type exp_rsp;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            exp_rsp = pending_rsp.pop_front();
            check_field("cursor_col", exp_rsp.cursor_col, rsp_data.cursor_col);
            check_field("cursor_row", exp_rsp.cursor_row, rsp_data.cursor_row);
            check_field("bell", exp_rsp.bell, rsp_data.bell);
            check_field("scrolled", exp_rsp.scrolled, rsp_data.scrolled);
            check_field("cell_char", exp_rsp.cell_char, rsp_data.cell_char);
            check_field("cell_attr", exp_rsp.cell_attr, rsp_data.cell_attr);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int         mode;
      bit         gapless;
      int         pause_at;
      logic [7:0] attr_set [PHASE_COUNT];

      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      mismatch_count = 0;
      stall_cycles   = 0;
      fill_attr      = RESET_ATTR;
      cur_col        = 0;
      cur_row        = 0;
      fill_screen_img();

      dir_tab = '{
         '{mk_req(CMD_READ, 8'h00, 5'd0, 7'd0), 1'b1,
           mk_rsp(7'd0, 5'd0, 1'b0, 1'b0, SPACE_CODE, RESET_ATTR)},
         '{mk_req(CMD_READ, 8'h00, 5'd24, 7'd79), 1'b1,
           mk_rsp(7'd0, 5'd0, 1'b0, 1'b0, SPACE_CODE, RESET_ATTR)},
         '{mk_req(CMD_READ, 8'hFF, 5'd31, 7'd127), 1'b1, '0},
         '{mk_req(CMD_READ, 8'h00, 5'd0, 7'd80), 1'b1, '0},
         '{mk_req(CMD_READ, 8'h00, 5'd25, 7'd0), 1'b1, '0},
         '{mk_req(CMD_PUT, CH_BELL, 5'd0, 7'd0), 1'b1,
           mk_rsp(7'd0, 5'd0, 1'b1, 1'b0, 8'h00, 8'h00)},
         '{mk_req(CMD_PUT, CH_BACKSPACE, 5'd0, 7'd0), 1'b1, '0},
         '{mk_req(CMD_PUT, 8'h41, 5'd0, 7'd0), 1'b0, '0},
         '{mk_req(CMD_PUT, 8'hFF, 5'd31, 7'd127), 1'b0, '0},
         '{mk_req(CMD_PUT, 8'h00, 5'd0, 7'd0), 1'b0, '0},
         '{mk_req(CMD_PUT, CH_BACKSPACE, 5'd0, 7'd0), 1'b0, '0},
         '{mk_req(CMD_PUT, CH_TAB, 5'd0, 7'd0), 1'b0, '0},
         '{mk_req(CMD_PUT, CH_TAB, 5'd0, 7'd0), 1'b0, '0},
         '{mk_req(CMD_PUT, CH_CR, 5'd0, 7'd0), 1'b0, '0},
         '{mk_req(CMD_PUT, CH_TAB, 5'd0, 7'd0), 1'b0, '0},
         '{mk_req(CMD_PUT, CH_LF, 5'd0, 7'd0), 1'b0, '0},
         '{mk_req(CMD_READ, 8'h00, 5'd0, 7'd0), 1'b0, '0},
         '{mk_req(CMD_READ, 8'h00, 5'd0, 7'd1), 1'b0, '0},
         '{mk_req(CMD_NONE, 8'hFF, 5'd31, 7'd127), 1'b0, '0},
         '{mk_req(CMD_CLEAR, 8'hFF, 5'd31, 7'd127), 1'b1, '0},
         '{mk_req(CMD_READ, 8'h00, 5'd0, 7'd0), 1'b1,
           mk_rsp(7'd0, 5'd0, 1'b0, 1'b0, SPACE_CODE, RESET_ATTR)}
      };

      attr_set[0] = 8'h00;
      attr_set[1] = 8'hFF;
      attr_set[2] = 8'($urandom_range(0, 255));
      attr_set[3] = 8'hA5;
      attr_set[4] = 8'($urandom_range(0, 255));
      attr_set[5] = RESET_ATTR;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         send_request(dir_tab[i].req, dir_tab[i].fixed_exp, dir_tab[i].rsp, 1'b0);

      pause_at = $urandom_range(50, 250);
      mode     = 0;
      gapless  = 1'b0;
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         drain_all();
         write_fill_attr(attr_set[ph]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % SEGMENT_LEN == 0) begin
               mode    = $urandom_range(0, 2);
               gapless = ($urandom_range(0, 2) == 0);
            end
            if (ph == 1 && n == pause_at) drain_all();
            send_request(random_req(mode), 1'b0, '0, gapless);
         end
      end

      drain_all();
      repeat (20) @(posedge clock);
      if (pending_rsp.size() != 0) begin
         $error("%0d responses never arrived", pending_rsp.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/text_console_writer_core.sv
verif/text_console_writer_core_tb.sv
